// ===== rtl/core/lci_pkg.sv =====
`timescale 1ns / 1ps
package lci_pkg;

  // Default Q1.F fraction width of the livetime ratio.
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Fixed field widths.
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned TS_W      = 48;
  localparam int unsigned CUR_W     = 32;
  localparam int unsigned CHARGE_W  = 64;
  localparam int unsigned IN_DATA_W = 152;
  localparam int unsigned OUT_DATA_W = 512;

endpackage

// ===== rtl/core/live_charge_integrator.sv =====
`timescale 1ns / 1ps
// Live charge integrator. Each input item is one checkpoint (scaler or beam
// current) and produces one output item holding every total after that
// checkpoint. Items are handled one at a time. Every item passes the pair
// check and the final step; a scaler checkpoint that yields a new livetime
// fraction first runs the restoring divider (one quotient bit per cycle),
// and a valid pair then runs the two bit-serial shift-add multipliers
// (fraction times interval, then that product times the current sum) and
// the accumulation step. The final step publishes once the output is free.
// A new item is taken while the previous result still waits at the output.
module live_charge_integrator
  import lci_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration: bit 0 is use_pass_flags.
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata from bit 0: gated_count[31:0], ungated_count[63:32],
  // timestamp[111:64], reading_present[112], current_reading[144:113],
  // row_passed[145], zero pad[151:146].
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // tuser: action (0 scaler, 1 current).
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tdata from bit 0: gated_charge_sum[63:0], gated_live_sum[111:64],
  // gated_time_sum[159:112], all_charge_sum[223:160], all_live_sum[271:224],
  // all_time_sum[319:272], pair_count[351:320], kept_count[383:352],
  // gated_used_count[415:384], gated_drop_count[447:416],
  // all_used_count[479:448], all_drop_count[511:480].
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned FW  = FRACTION_BITS + 1;
  localparam int unsigned PW  = TS_W + FW;
  localparam int unsigned SW  = CUR_W + 1;
  localparam int unsigned XW  = PW + SW;
  localparam int unsigned CW  = $clog2(PW + 1);
  localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};
  localparam logic [COUNT_W-1:0] CNT_MAX = {COUNT_W{1'b1}};
  localparam logic [CHARGE_W-1:0] CH_MAX = {1'b0, {(CHARGE_W-1){1'b1}}};
  localparam logic [CHARGE_W-1:0] CH_MIN = {1'b1, {(CHARGE_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_PAIR, ST_MUL1, ST_MUL2, ST_ACC, ST_FIN
  } state_t;

  state_t state_r;
  logic   use_pass_r;

  logic [COUNT_W-1:0] last_g_r, last_u_r;
  logic [FW-1:0]      frac_r;
  logic               frac_known_r;
  logic [CUR_W-1:0]   cur_r;
  logic               cur_known_r;
  logic [TS_W-1:0]    prior_ts_r;
  logic [CUR_W-1:0]   prior_cur_r;
  logic               prior_cur_known_r, prior_pass_r, have_prior_r;

  logic [TS_W-1:0]    ts_r;
  logic               pass_r;

  logic [COUNT_W:0]   rem_r;
  logic [COUNT_W-1:0] den_r;
  logic [FW-1:0]      quo_r;
  logic [CW-1:0]      cnt_r;
  logic [PW-1:0]      prod_r;
  logic [XW-1:0]      xprod_r;
  logic [SW-1:0]      asum_r;
  logic               neg_r, gate_r;

  logic [CHARGE_W-1:0] g_charge_r, a_charge_r;
  logic [TS_W-1:0]     g_live_r, g_time_r, a_live_r, a_time_r;
  logic [COUNT_W-1:0]  pair_cnt_r, kept_r, g_used_r, g_drop_r, a_used_r, a_drop_r;

  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Input field split.
  logic [COUNT_W-1:0] in_g, in_u;
  logic [TS_W-1:0]    in_ts;
  logic               in_present, in_passed;
  logic [CUR_W-1:0]   in_cur;
  assign in_g       = in_tdata[31:0];
  assign in_u       = in_tdata[63:32];
  assign in_ts      = in_tdata[111:64];
  assign in_present = in_tdata[112];
  assign in_cur     = in_tdata[144:113];
  assign in_passed  = in_tdata[145];

  // Counter deltas with rebase on a falling counter.
  logic               fall;
  logic [COUNT_W-1:0] dg, du;
  assign fall = (in_g < last_g_r) || (in_u < last_u_r);
  assign dg   = in_g - (fall ? '0 : last_g_r);
  assign du   = in_u - (fall ? '0 : last_u_r);

  // One restoring division step.
  logic [COUNT_W:0] div_trial;
  logic             div_bit;
  assign div_trial = (cnt_r == '0) ? rem_r : {rem_r[COUNT_W-1:0], 1'b0};
  assign div_bit   = div_trial >= {1'b0, den_r};

  // Pair checks.
  logic pair_ok, pair_gate;
  assign pair_gate = !use_pass_r || (prior_pass_r && pass_r);
  assign pair_ok   = (prior_ts_r != '0) && (ts_r != '0) && (ts_r > prior_ts_r) &&
                     frac_known_r && prior_cur_known_r && cur_known_r;

  // Current sum; its magnitude is taken in the pair step.
  logic [SW-1:0] cur_sum;
  assign cur_sum = {prior_cur_r[CUR_W-1], prior_cur_r} + {cur_r[CUR_W-1], cur_r};

  // Shift-add step sums.
  logic [FW:0] mul1_sum;
  logic [SW:0] mul2_sum;
  assign mul1_sum = {1'b0, prod_r[PW-1:TS_W]} + (prod_r[0] ? {1'b0, frac_r} : '0);
  assign mul2_sum = {1'b0, xprod_r[XW-1:PW]} + (xprod_r[0] ? {1'b0, asum_r} : '0);

  // Charge increment with saturation of the magnitude.
  logic [CHARGE_W-1:0] ch_mag, dq;
  logic                ch_big;
  logic [TS_W-1:0]     live;
  assign ch_mag = xprod_r[FRACTION_BITS+CHARGE_W:FRACTION_BITS+1];
  assign ch_big = (|xprod_r[XW-1:FRACTION_BITS+CHARGE_W+1]) || ch_mag[CHARGE_W-1];
  assign dq     = ch_big ? (neg_r ? CH_MIN : CH_MAX) : (neg_r ? (~ch_mag + 1'b1) : ch_mag);
  assign live   = prod_r[FRACTION_BITS+TS_W-1:FRACTION_BITS];

  // Saturating adders for the accumulation step.
  function automatic logic [CHARGE_W-1:0] add_s64(input logic [CHARGE_W-1:0] a,
                                                  input logic [CHARGE_W-1:0] d);
    logic [CHARGE_W:0] s;
    s = {a[CHARGE_W-1], a} + {d[CHARGE_W-1], d};
    if (s[CHARGE_W] != s[CHARGE_W-1]) return s[CHARGE_W] ? CH_MIN : CH_MAX;
    return s[CHARGE_W-1:0];
  endfunction

  function automatic logic [TS_W-1:0] add_u48(input logic [TS_W-1:0] a,
                                              input logic [TS_W-1:0] d);
    logic [TS_W:0] s;
    s = {1'b0, a} + {1'b0, d};
    return s[TS_W] ? TS_MAX : s[TS_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] inc_sat(input logic [COUNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Sequencer, state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      use_pass_r        <= 1'b0;
      last_g_r          <= '0;
      last_u_r          <= '0;
      frac_r            <= '0;
      frac_known_r      <= 1'b0;
      cur_r             <= '0;
      cur_known_r       <= 1'b0;
      prior_ts_r        <= '0;
      prior_cur_r       <= '0;
      prior_cur_known_r <= 1'b0;
      prior_pass_r      <= 1'b0;
      have_prior_r      <= 1'b0;
      g_charge_r        <= '0;
      a_charge_r        <= '0;
      g_live_r          <= '0;
      g_time_r          <= '0;
      a_live_r          <= '0;
      a_time_r          <= '0;
      pair_cnt_r        <= '0;
      kept_r            <= '0;
      g_used_r          <= '0;
      g_drop_r          <= '0;
      a_used_r          <= '0;
      a_drop_r          <= '0;
      out_valid_r       <= 1'b0;
      cnt_r             <= '0;
    end else begin
      if (cfg_wr_en) begin
        use_pass_r <= cfg_wr_data;
      end
      // The final step sets the valid flag itself when it publishes.
      if (out_valid_r && out_tready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            ts_r   <= in_ts;
            pass_r <= in_passed;
            cnt_r  <= '0;
            if (!in_tuser) begin
              last_g_r <= in_g;
              last_u_r <= in_u;
              rem_r    <= {1'b0, dg};
              den_r    <= du;
              state_r  <= (du != '0 && dg <= du) ? ST_DIV : ST_PAIR;
            end else begin
              if (in_present) begin
                cur_r       <= in_cur;
                cur_known_r <= 1'b1;
              end
              state_r <= ST_PAIR;
            end
          end
        end

        // One quotient bit a cycle.
        ST_DIV: begin
          rem_r <= div_bit ? (div_trial - {1'b0, den_r}) : div_trial;
          quo_r <= {quo_r[FW-2:0], div_bit};
          if (cnt_r == CW'(FRACTION_BITS)) begin
            frac_r       <= {quo_r[FW-2:0], div_bit};
            frac_known_r <= 1'b1;
            state_r      <= ST_PAIR;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end

        ST_PAIR: begin
          cnt_r  <= '0;
          gate_r <= pair_gate;
          neg_r  <= cur_sum[SW-1];
          asum_r <= cur_sum[SW-1] ? (~cur_sum + 1'b1) : cur_sum;
          prod_r <= {{FW{1'b0}}, ts_r - prior_ts_r};
          if (!have_prior_r) begin
            state_r <= ST_FIN;
          end else begin
            pair_cnt_r <= inc_sat(pair_cnt_r);
            if (pair_gate) kept_r <= inc_sat(kept_r);
            if (!pair_ok) begin
              if (pair_gate) g_drop_r <= inc_sat(g_drop_r);
              a_drop_r <= inc_sat(a_drop_r);
              state_r  <= ST_FIN;
            end else begin
              state_r <= ST_MUL1;
            end
          end
        end

        // Fraction times interval, one interval bit a cycle.
        ST_MUL1: begin
          prod_r <= {mul1_sum, prod_r[TS_W-1:1]};
          if (cnt_r == CW'(TS_W - 1)) begin
            cnt_r   <= '0;
            state_r <= ST_MUL2;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end

        // Product times current magnitude: load the product, then one product bit a cycle.
        ST_MUL2: begin
          if (cnt_r == '0) begin
            xprod_r <= {{SW{1'b0}}, prod_r};
            cnt_r   <= cnt_r + 1'b1;
          end else begin
            xprod_r <= {mul2_sum, xprod_r[PW-1:1]};
            if (cnt_r == CW'(PW)) begin
              state_r <= ST_ACC;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end

        ST_ACC: begin
          a_charge_r <= add_s64(a_charge_r, dq);
          a_live_r   <= add_u48(a_live_r, live);
          a_used_r   <= inc_sat(a_used_r);
          if (gate_r) begin
            g_charge_r <= add_s64(g_charge_r, dq);
            g_live_r   <= add_u48(g_live_r, live);
            g_used_r   <= inc_sat(g_used_r);
          end
          a_time_r <= add_u48(a_time_r, ts_r - prior_ts_r);
          if (gate_r) g_time_r <= add_u48(g_time_r, ts_r - prior_ts_r);
          state_r <= ST_FIN;
        end

        // Commit the checkpoint and publish the totals.
        ST_FIN: begin
          if (!out_valid_r || out_tready) begin
            prior_ts_r        <= ts_r;
            prior_cur_r       <= cur_r;
            prior_cur_known_r <= cur_known_r;
            prior_pass_r      <= pass_r;
            have_prior_r      <= 1'b1;
            out_valid_r       <= 1'b1;
            out_data_r <= {a_drop_r, a_used_r, g_drop_r, g_used_r, kept_r, pair_cnt_r,
                           a_time_r, a_live_r, a_charge_r,
                           g_time_r, g_live_r, g_charge_r};
            state_r <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // An accepted item blocks the input until its result is published.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again before the item finished");

  // A free output slot in the final step always yields a result.
  a_fin_publishes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) && (!out_valid_r || out_tready) |=> out_valid_r)
    else $error("final step did not publish a result");

  // Used pairs never outnumber the pairs seen or the passing pairs.
  a_counts_order: assert property (@(posedge clk) disable iff (!rst_n)
    (pair_cnt_r >= a_used_r) && (kept_r >= g_used_r) && (a_used_r >= g_used_r))
    else $error("pair counters out of order");

endmodule
